FILE: hw/rtl/clock_calendar_set_editor_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the clock calendar set editor
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef CLOCK_CALENDAR_SET_EDITOR_MACROS_SVH
`define CLOCK_CALENDAR_SET_EDITOR_MACROS_SVH

`ifndef SYNTH
// Implication check on every clock edge out of reset
`define CCSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("clock calendar set editor: assertion failed");
// Condition that must never be seen out of reset
`define CCSE_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("clock calendar set editor: forbidden condition seen");
`else
`define CCSE_ASSERT(label, prop)
`define CCSE_ASSERT_NEVER(label, cond)
`endif

`endif

FILE: hw/rtl/ccse_pkg.sv
// ---------------------------------------------------------------------------
// ccse_pkg
// Widths, codes, item types and calendar helpers for the set editor.
// ---------------------------------------------------------------------------
`default_nettype none

package ccse_pkg;

  // Field widths
  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int MODE_W    = 2;
  localparam int SEL_W     = 3;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  // Year limit reset values
  localparam logic [YEAR_W-1:0] YEAR_FLOOR_RST   = 12'd1970;
  localparam logic [YEAR_W-1:0] YEAR_CEILING_RST = 12'd2070;

  // Key codes
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
  localparam logic [OP_W-1:0] OP_INC     = 2'd1;
  localparam logic [OP_W-1:0] OP_DEC     = 2'd2;
  localparam logic [OP_W-1:0] OP_COMMIT  = 2'd3;

  // Edit modes
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TIME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DATE = 2'd2;

  // Field selection
  localparam logic [SEL_W-1:0] SEL_HOUR  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_MIN   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_SEC   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_YEAR  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_MONTH = 3'd4;
  localparam logic [SEL_W-1:0] SEL_DAY   = 3'd5;

  // Field limits
  localparam logic [HOUR_W-1:0]  HOUR_TOP  = 5'd23;
  localparam logic [MIN_W-1:0]   MIN_TOP   = 6'd59;
  localparam logic [SEC_W-1:0]   SEC_TOP   = 6'd59;
  localparam logic [MONTH_W-1:0] MONTH_TOP = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_BOT = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_BOT   = 5'd1;

  // Reciprocal of 25 scaled by 2^17, exact for every 12-bit year
  localparam int          DIV25_SHIFT = 17;
  localparam logic [12:0] DIV25_RECIP = 13'd5243;
  localparam logic [7:0]  DIV25       = 8'd25;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YEAR_FLOOR   = 1'b0,
    CFG_YEAR_CEILING = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [YEAR_W-1:0]  now_year;
    logic [MONTH_W-1:0] now_month;
    logic [DAY_W-1:0]   now_day;
    logic [HOUR_W-1:0]  now_hour;
    logic [MIN_W-1:0]   now_minute;
    logic [SEC_W-1:0]   now_second;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  edit_mode;
    logic [SEL_W-1:0]   selected_field;
    logic [YEAR_W-1:0]  edit_year;
    logic [MONTH_W-1:0] edit_month;
    logic [DAY_W-1:0]   edit_day;
    logic [HOUR_W-1:0]  edit_hour;
    logic [MIN_W-1:0]   edit_minute;
    logic [SEC_W-1:0]   edit_second;
    logic               commit_strobe;
  } out_item_t;

  // Edit copy of the clock value
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } date_time_t;

  // Gregorian leap test: divisible by 4 but not 100, or by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [YEAR_W+12:0] prod;
    logic [7:0]         quot;
    logic [YEAR_W-1:0]  back;
    logic               div4;
    logic               div16;
    logic               div25;
    prod  = (YEAR_W+13)'(year) * (YEAR_W+13)'(DIV25_RECIP);
    quot  = prod[DIV25_SHIFT +: 8];
    back  = YEAR_W'(quot) * YEAR_W'(DIV25);
    div25 = (back == year);
    div4  = (year[1:0] == 2'd0);
    div16 = (year[3:0] == 4'd0);
    return (div16 && div25) || (div4 && !div25);
  endfunction

  // Days in a month; codes outside 1..12 count as 31 days
  function automatic logic [DAY_W-1:0] month_length(input logic [YEAR_W-1:0]  year,
                                                    input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2:                  len = is_leap(year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:               len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ccse_adjust.sv
// ---------------------------------------------------------------------------
// ccse_adjust
// Steps the selected field of the edit copy up or down with wrap-around.
// ---------------------------------------------------------------------------
`default_nettype none

module ccse_adjust
  import ccse_pkg::*;
(
  input  logic [SEL_W-1:0]  field_i,
  input  logic              up_i,
  input  logic [YEAR_W-1:0] year_floor_i,
  input  logic [YEAR_W-1:0] year_ceiling_i,
  input  date_time_t        cur_i,
  output date_time_t        nxt_o
);

  logic [DAY_W-1:0] len;

  assign len = month_length(cur_i.year, cur_i.month);

  // Update only the selected field, hold the rest
  always_comb begin
    nxt_o = cur_i;
    case (field_i)
      SEL_HOUR: begin
        if (up_i) begin
          nxt_o.hour = (cur_i.hour >= HOUR_TOP) ? '0 : cur_i.hour + 1'b1;
        end else begin
          nxt_o.hour = (cur_i.hour == '0 || cur_i.hour > HOUR_TOP) ? HOUR_TOP
                                                                   : cur_i.hour - 1'b1;
        end
      end
      SEL_MIN: begin
        if (up_i) begin
          nxt_o.minute = (cur_i.minute >= MIN_TOP) ? '0 : cur_i.minute + 1'b1;
        end else begin
          nxt_o.minute = (cur_i.minute == '0 || cur_i.minute > MIN_TOP) ? MIN_TOP
                                                                        : cur_i.minute - 1'b1;
        end
      end
      SEL_SEC: begin
        if (up_i) begin
          nxt_o.second = (cur_i.second >= SEC_TOP) ? '0 : cur_i.second + 1'b1;
        end else begin
          nxt_o.second = (cur_i.second == '0 || cur_i.second > SEC_TOP) ? SEC_TOP
                                                                        : cur_i.second - 1'b1;
        end
      end
      SEL_YEAR: begin
        if (up_i) begin
          nxt_o.year = (cur_i.year >= year_ceiling_i) ? year_floor_i : cur_i.year + 1'b1;
        end else begin
          nxt_o.year = (cur_i.year <= year_floor_i) ? year_ceiling_i : cur_i.year - 1'b1;
        end
      end
      SEL_MONTH: begin
        if (up_i) begin
          nxt_o.month = (cur_i.month >= MONTH_TOP) ? MONTH_BOT : cur_i.month + 1'b1;
        end else begin
          nxt_o.month = (cur_i.month <= MONTH_BOT || cur_i.month > MONTH_TOP)
                        ? MONTH_TOP : cur_i.month - 1'b1;
        end
      end
      SEL_DAY: begin
        // A day beyond the month length wraps to the first on increment
        if (up_i) begin
          nxt_o.day = (cur_i.day >= len) ? DAY_BOT : cur_i.day + 1'b1;
        end else begin
          nxt_o.day = (cur_i.day <= DAY_BOT) ? len : cur_i.day - 1'b1;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/clock_calendar_set_editor.sv
// ---------------------------------------------------------------------------
// clock_calendar_set_editor
// Key-driven editor for the time and date of a clock, with commit strobe.
// ---------------------------------------------------------------------------
// Path: an accepted key is held in the input register, then the result
// register is loaded together with the edit state.
// Throughput: one item per cycle unless the receiver stalls.
// Reset: asynchronous, active low; idle, hour selected, edit copy
// 0000-01-01 00:00:00, year limits 1970 and 2070, both channels empty.
`default_nettype none

`include "clock_calendar_set_editor_macros.svh"

module clock_calendar_set_editor
  import ccse_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [YEAR_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  logic [YEAR_W-1:0] year_floor_q, year_ceiling_q;
  logic              s1_valid_q;
  in_item_t          s1_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [SEL_W-1:0]  field_q, field_d;
  date_time_t        edit_q, edit_d, adj;
  logic              strobe_d;
  logic              advance;
  logic              fire;
  cfg_reg_e          cfg_idx;

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = s1_valid_q && advance;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_idx     = cfg_reg_e'(cfg_idx_i);

  // Write the year limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_floor_q   <= YEAR_FLOOR_RST;
      year_ceiling_q <= YEAR_CEILING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        CFG_YEAR_FLOOR:   year_floor_q   <= cfg_wdata_i;
        CFG_YEAR_CEILING: year_ceiling_q <= cfg_wdata_i;
        default:          year_floor_q   <= year_floor_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  ccse_adjust u_adjust (
    .field_i        (field_q),
    .up_i           (s1_q.opcode == OP_INC),
    .year_floor_i   (year_floor_q),
    .year_ceiling_i (year_ceiling_q),
    .cur_i          (edit_q),
    .nxt_o          (adj)
  );

  // Decode the key against the current edit state
  always_comb begin
    mode_d   = mode_q;
    field_d  = field_q;
    edit_d   = edit_q;
    strobe_d = 1'b0;
    if (mode_q == MODE_IDLE) begin
      if (s1_q.opcode == OP_ADVANCE) begin
        edit_d.year   = s1_q.now_year;
        edit_d.month  = s1_q.now_month;
        edit_d.day    = s1_q.now_day;
        edit_d.hour   = s1_q.now_hour;
        edit_d.minute = s1_q.now_minute;
        edit_d.second = s1_q.now_second;
        mode_d        = MODE_TIME;
        field_d       = SEL_HOUR;
      end
    end else begin
      case (s1_q.opcode)
        OP_ADVANCE: begin
          // Leave without saving after the day field
          if (field_q >= SEL_DAY) begin
            field_d = SEL_HOUR;
            mode_d  = MODE_IDLE;
          end else begin
            field_d = field_q + 1'b1;
            if (field_d > SEL_SEC) begin
              mode_d = MODE_DATE;
            end
          end
        end
        OP_INC, OP_DEC: begin
          edit_d = adj;
        end
        OP_COMMIT: begin
          strobe_d = 1'b1;
          mode_d   = MODE_IDLE;
          field_d  = SEL_HOUR;
        end
        default: begin
          edit_d = edit_q;
        end
      endcase
    end
  end

  // Edit state, updated as each item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      field_q       <= SEL_HOUR;
      edit_q.year   <= '0;
      edit_q.month  <= MONTH_BOT;
      edit_q.day    <= DAY_BOT;
      edit_q.hour   <= '0;
      edit_q.minute <= '0;
      edit_q.second <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      field_q <= field_d;
      edit_q  <= edit_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.edit_mode      <= mode_d;
      out_q.selected_field <= field_d;
      out_q.edit_year      <= edit_d.year;
      out_q.edit_month     <= edit_d.month;
      out_q.edit_day       <= edit_d.day;
      out_q.edit_hour      <= edit_d.hour;
      out_q.edit_minute    <= edit_d.minute;
      out_q.edit_second    <= edit_d.second;
      out_q.commit_strobe  <= strobe_d;
    end
  end

  // Checks
  `CCSE_ASSERT(a_idle_selects_hour, (mode_q == MODE_IDLE) |-> (field_q == SEL_HOUR))
  `CCSE_ASSERT(a_fire_gives_result, fire |=> out_valid_q)
  `CCSE_ASSERT(a_commit_ends_edit,
               (out_valid_q && out_q.commit_strobe) |-> (mode_q == MODE_IDLE))
  `CCSE_ASSERT_NEVER(a_date_field_in_time, (mode_q == MODE_TIME) && (field_q > SEL_SEC))

endmodule

`default_nettype wire

FILE: sim/tb_clock_calendar_set_editor.sv
// ---------------------------------------------------------------------------
// tb_clock_calendar_set_editor
// Self-checking bench for the clock calendar set editor. A short table of
// keys walks every field through its wrap points, then random edit sessions
// run under several year-limit settings. Every key accepted is fed to a
// behavioural copy of the editor, and each result item is compared field by
// field with the oldest prediction. Sender bursts and receiver stalls vary
// throughout.
// ---------------------------------------------------------------------------

module tb_clock_calendar_set_editor;
  import ccse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 1000;

  typedef struct {
    in_item_t  key;
    bit        fixed;
    out_item_t want;
  } key_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [YEAR_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;

  // Editor copy kept by the bench
  logic [MODE_W-1:0] ed_mode;
  logic [SEL_W-1:0]  ed_sel;
  date_time_t        ed_copy;
  logic [YEAR_W-1:0] lim_floor;
  logic [YEAR_W-1:0] lim_ceiling;

  out_item_t   pending_views[$];
  key_row_t    key_plan[$];
  bit          cur_fixed;
  out_item_t   cur_view;
  int unsigned burst_left;
  int unsigned keys_sent;
  int unsigned commits_seen;
  int unsigned error_count;
  int unsigned quiet_cycles = 0;

  clock_calendar_set_editor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gregorian leap year
  function automatic bit leap_year(logic [YEAR_W-1:0] y);
    int unsigned v;
    v = y;
    return (v % 400 == 0) || ((v % 4 == 0) && (v % 100 != 0));
  endfunction

  // Length of a month; unknown month codes count as 31 days
  function automatic int unsigned days_of_month(logic [YEAR_W-1:0] y,
                                                logic [MONTH_W-1:0] m);
    case (m)
      4'd2:                    return leap_year(y) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default:                 return 31;
    endcase
  endfunction

  function automatic int unsigned roll_up(int unsigned v, int unsigned top,
                                          int unsigned bot);
    return (v >= top) ? bot : v + 1;
  endfunction

  function automatic int unsigned roll_down(int unsigned v, int unsigned top,
                                            int unsigned bot);
    if (v <= bot) return top;
    if (v > top) return top;
    return v - 1;
  endfunction

  // Apply one key to the bench copy and return the view it leaves
  function automatic out_item_t apply_key(in_item_t k);
    out_item_t   r;
    logic        strobe;
    int unsigned len;
    bit          up;
    strobe = 1'b0;
    len    = days_of_month(ed_copy.year, ed_copy.month);
    up     = (k.opcode == OP_INC);
    if (ed_mode == MODE_IDLE) begin
      if (k.opcode == OP_ADVANCE) begin
        ed_copy.year   = k.now_year;
        ed_copy.month  = k.now_month;
        ed_copy.day    = k.now_day;
        ed_copy.hour   = k.now_hour;
        ed_copy.minute = k.now_minute;
        ed_copy.second = k.now_second;
        ed_mode        = MODE_TIME;
        ed_sel         = SEL_HOUR;
      end
    end else if (k.opcode == OP_ADVANCE) begin
      if (ed_sel >= SEL_DAY) begin
        ed_sel  = SEL_HOUR;
        ed_mode = MODE_IDLE;
      end else begin
        ed_sel = ed_sel + 1'b1;
        if (ed_sel > SEL_SEC) ed_mode = MODE_DATE;
      end
    end else if (k.opcode == OP_COMMIT) begin
      strobe  = 1'b1;
      ed_mode = MODE_IDLE;
      ed_sel  = SEL_HOUR;
    end else begin
      case (ed_sel)
        SEL_HOUR: ed_copy.hour = up ? roll_up(ed_copy.hour, HOUR_TOP, 0)
                                    : roll_down(ed_copy.hour, HOUR_TOP, 0);
        SEL_MIN: ed_copy.minute = up ? roll_up(ed_copy.minute, MIN_TOP, 0)
                                     : roll_down(ed_copy.minute, MIN_TOP, 0);
        SEL_SEC: ed_copy.second = up ? roll_up(ed_copy.second, SEC_TOP, 0)
                                     : roll_down(ed_copy.second, SEC_TOP, 0);
        SEL_YEAR: begin
          if (up) ed_copy.year = roll_up(ed_copy.year, lim_ceiling, lim_floor);
          else ed_copy.year = (ed_copy.year <= lim_floor) ? lim_ceiling
                                                          : ed_copy.year - 1'b1;
        end
        SEL_MONTH: ed_copy.month = up ? roll_up(ed_copy.month, MONTH_TOP, MONTH_BOT)
                                      : roll_down(ed_copy.month, MONTH_TOP, MONTH_BOT);
        SEL_DAY: begin
          if (up) ed_copy.day = roll_up(ed_copy.day, len, DAY_BOT);
          else ed_copy.day = (ed_copy.day <= DAY_BOT) ? len : ed_copy.day - 1'b1;
        end
        default: ;
      endcase
    end
    r.edit_mode      = ed_mode;
    r.selected_field = ed_sel;
    r.edit_year      = ed_copy.year;
    r.edit_month     = ed_copy.month;
    r.edit_day       = ed_copy.day;
    r.edit_hour      = ed_copy.hour;
    r.edit_minute    = ed_copy.minute;
    r.edit_second    = ed_copy.second;
    r.commit_strobe  = strobe;
    return r;
  endfunction

  function automatic in_item_t key_of(logic [OP_W-1:0] op, int unsigned y, int unsigned mo,
                                      int unsigned d, int unsigned h, int unsigned mi,
                                      int unsigned s);
    in_item_t k;
    k.opcode     = op;
    k.now_year   = y;
    k.now_month  = mo;
    k.now_day    = d;
    k.now_hour   = h;
    k.now_minute = mi;
    k.now_second = s;
    return k;
  endfunction

  function automatic out_item_t view_of(logic [MODE_W-1:0] mode, logic [SEL_W-1:0] sel,
                                        int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s,
                                        logic strobe);
    out_item_t r;
    r.edit_mode      = mode;
    r.selected_field = sel;
    r.edit_year      = y;
    r.edit_month     = mo;
    r.edit_day       = d;
    r.edit_hour      = h;
    r.edit_minute    = mi;
    r.edit_second    = s;
    r.commit_strobe  = strobe;
    return r;
  endfunction

  function automatic in_item_t rand_payload();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic add_row(in_item_t k, bit fixed, out_item_t w);
    key_row_t row;
    row.key   = k;
    row.fixed = fixed;
    row.want  = w;
    key_plan.push_back(row);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Offer one key; open a new burst after a random gap when the last one ran out
  task automatic send_key(in_item_t k, bit fixed, out_item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i = 1'b1;
    in_data_i  = k;
    cur_fixed  = fixed;
    cur_view   = w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    keys_sent++;
  endtask

  // Drain, then write both year limits while the editor is quiet
  task automatic write_limits(logic [YEAR_W-1:0] fl, logic [YEAR_W-1:0] ce);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_views.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_YEAR_FLOOR;
    cfg_wdata_i = fl;
    @(negedge clk_i);
    cfg_idx_i   = CFG_YEAR_CEILING;
    cfg_wdata_i = ce;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    lim_floor   = fl;
    lim_ceiling = ce;
    @(negedge clk_i);
  endtask

  // One edit session: enter with a biased clock value, jump to a field, then
  // a run of mostly well-formed keys; a few sessions are a single stray key
  task automatic run_session();
    in_item_t    k;
    int unsigned n;
    int unsigned pick;
    if ($urandom_range(0, 9) == 0) begin
      send_key(rand_payload(), 1'b0, '0);
      return;
    end
    if (ed_mode != MODE_IDLE) begin
      k = rand_payload();
      k.opcode = OP_COMMIT;
      send_key(k, 1'b0, '0);
    end
    k = rand_payload();
    k.opcode = OP_ADVANCE;
    case ($urandom_range(0, 9))
      0:       k.now_year = '0;
      1:       k.now_year = '1;
      2:       k.now_year = 12'd1900;
      3:       k.now_year = 12'd2000;
      4:       k.now_year = 12'd2100;
      5:       k.now_year = lim_floor;
      6:       k.now_year = lim_ceiling;
      7:       k.now_year = lim_floor - 1'b1;
      8:       k.now_year = k.now_year & ~12'd3;
      default: ;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 3) k.now_month = 4'd2;
    else if (pick == 3) k.now_month = $urandom_range(0, 1) ? 4'd0 : $urandom_range(13, 15);
    else k.now_month = $urandom_range(1, 12);
    pick = $urandom_range(0, 9);
    if (pick < 4) k.now_day = $urandom_range(28, 31);
    else if (pick == 4) k.now_day = '0;
    if ($urandom_range(0, 4) != 0) k.now_hour = $urandom_range(0, 23);
    if ($urandom_range(0, 4) != 0) k.now_minute = $urandom_range(0, 59);
    if ($urandom_range(0, 4) != 0) k.now_second = $urandom_range(0, 59);
    send_key(k, 1'b0, '0);
    // jump towards a field
    repeat ($urandom_range(0, 5)) begin
      k = rand_payload();
      k.opcode = OP_ADVANCE;
      send_key(k, 1'b0, '0);
    end
    n = $urandom_range(1, 40);
    while (n != 0 && ed_mode != MODE_IDLE) begin
      k = rand_payload();
      pick = $urandom_range(0, 99);
      if (pick < 15) k.opcode = OP_ADVANCE;
      else if (pick < 55) k.opcode = OP_INC;
      else if (pick < 92) k.opcode = OP_DEC;
      else if (pick < 97) k.opcode = OP_COMMIT;
      send_key(k, 1'b0, '0);
      n--;
    end
  endtask

  // Receiver: rotate a stall pattern, renewed every so often
  initial begin
    logic [7:0]  ready_pat;
    int unsigned pat_left;
    out_ready_i = 1'b0;
    ready_pat   = 8'hFF;
    pat_left    = 0;
    forever begin
      @(negedge clk_i);
      if (pat_left == 0) begin
        ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
        if (ready_pat == 8'h00) ready_pat = 8'h01;
        pat_left = $urandom_range(16, 128);
      end
      out_ready_i = ready_pat[0];
      ready_pat   = {ready_pat[0], ready_pat[7:1]};
      pat_left--;
    end
  end

  // Check results, then predict for the key taken at this edge
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t view;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_views.size() == 0) begin
          $error("result item with no prediction waiting");
          error_count++;
        end else begin
          want = pending_views.pop_front();
          compare_field("edit_mode", want.edit_mode, out_data_o.edit_mode);
          compare_field("selected_field", want.selected_field, out_data_o.selected_field);
          compare_field("edit_year", want.edit_year, out_data_o.edit_year);
          compare_field("edit_month", want.edit_month, out_data_o.edit_month);
          compare_field("edit_day", want.edit_day, out_data_o.edit_day);
          compare_field("edit_hour", want.edit_hour, out_data_o.edit_hour);
          compare_field("edit_minute", want.edit_minute, out_data_o.edit_minute);
          compare_field("edit_second", want.edit_second, out_data_o.edit_second);
          compare_field("commit_strobe", want.commit_strobe, out_data_o.commit_strobe);
        end
        if (out_data_o.commit_strobe) commits_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        view = apply_key(in_data_i);
        pending_views.push_back(cur_fixed ? cur_view : view);
      end
    end
  end

  // Count cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $error("no handshake for %0d cycles", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned       target;
    logic [YEAR_W-1:0] lo;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_YEAR_FLOOR;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cur_fixed    = 1'b0;
    cur_view     = '0;
    burst_left   = 0;
    keys_sent    = 0;
    commits_seen = 0;
    error_count  = 0;
    ed_mode      = MODE_IDLE;
    ed_sel       = SEL_HOUR;
    ed_copy      = '{year: '0, month: 4'd1, day: 5'd1, hour: '0, minute: '0, second: '0};
    lim_floor    = YEAR_FLOOR_RST;
    lim_ceiling  = YEAR_CEILING_RST;

    // Directed keys: idle keys, every wrap point of every field, empty copy
    add_row(key_of(OP_COMMIT, 0, 0, 0, 0, 0, 0), 1'b1,
            view_of(MODE_IDLE, SEL_HOUR, 0, 1, 1, 0, 0, 0, 1'b0));
    add_row(key_of(OP_INC, 4095, 15, 31, 31, 63, 63), 1'b1,
            view_of(MODE_IDLE, SEL_HOUR, 0, 1, 1, 0, 0, 0, 1'b0));
    add_row(key_of(OP_ADVANCE, 4095, 15, 31, 31, 63, 63), 1'b1,
            view_of(MODE_TIME, SEL_HOUR, 4095, 15, 31, 31, 63, 63, 1'b0));
    add_row(key_of(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // hour above range
    add_row(key_of(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // hour 23 wraps to 0
    add_row(key_of(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // hour 0 wraps to 23
    add_row(key_of(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // minute above range
    add_row(key_of(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // second above range
    add_row(key_of(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 1'b0, '0);  // into date setting
    add_row(key_of(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // year over ceiling
    add_row(key_of(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // year at floor
    add_row(key_of(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // month above range
    add_row(key_of(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);      // day at month end
    add_row(key_of(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(key_of(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 1'b0, '0);  // leave without saving
    add_row(key_of(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 1'b1,
            view_of(MODE_TIME, SEL_HOUR, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(key_of(OP_COMMIT, 0, 0, 0, 0, 0, 0), 1'b1,
            view_of(MODE_IDLE, SEL_HOUR, 0, 0, 0, 0, 0, 0, 1'b1));
    add_row(key_of(OP_COMMIT, 0, 0, 0, 0, 0, 0), 1'b1,
            view_of(MODE_IDLE, SEL_HOUR, 0, 0, 0, 0, 0, 0, 1'b0));

    // Hold reset low, then release it
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (key_plan[i]) send_key(key_plan[i].key, key_plan[i].fixed, key_plan[i].want);

    // Random sessions under each year-limit setting
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: ;
        1: write_limits(12'd0, 12'd4095);
        2: write_limits(12'd4095, 12'd0);
        3: write_limits(12'd2000, 12'd2000);
        4: write_limits(12'd1900, 12'd2100);
        5: begin
          lo = $urandom_range(0, 4000);
          write_limits(lo, lo + $urandom_range(0, 95));
        end
        default: write_limits(12'($urandom()), 12'($urandom()));
      endcase
      target = keys_sent + 245;
      while (keys_sent < target) run_session();
    end

    // Drain and let the pipeline settle
    in_valid_i = 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d keys (%0d from the table) under 7 year-limit settings,",
             keys_sent, key_plan.size());
    $display("with %0d commits observed and %0d mismatches.", commits_seen, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ccse_pkg.sv
hw/rtl/ccse_adjust.sv
hw/rtl/clock_calendar_set_editor.sv
sim/tb_clock_calendar_set_editor.sv
